// File: rtl/core/mts_pkg.sv
// Shared types and constants for the magnetorquer axis select block.
package mts_pkg;

  // Register map, word index taken from paddr[3:2]
  localparam logic [1:0] REG_GAIN_X  = 2'd0;
  localparam logic [1:0] REG_GAIN_Y  = 2'd1;
  localparam logic [1:0] REG_GAIN_Z  = 2'd2;
  localparam logic [1:0] REG_DIVISOR = 2'd3;

  localparam logic [15:0] RST_GAIN_X  = 16'd100;
  localparam logic [15:0] RST_GAIN_Y  = 16'd100;
  localparam logic [15:0] RST_GAIN_Z  = 16'd200;
  localparam logic [15:0] RST_DIVISOR = 16'd1000;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int OPA_W    = 33;             // cross term difference, signed
  localparam int OPB_W    = 17;             // sample or zero-extended gain, signed
  localparam int PROD_W   = OPA_W + OPB_W;
  localparam int TERM_W   = 32;             // one sample product
  localparam int MAG_W    = 48;             // score magnitude
  localparam int QUOT_W   = 7;              // unsaturated quotient magnitude

  localparam logic signed [7:0] POWER_MAX = 8'sd127;
  localparam logic signed [7:0] POWER_MIN = -8'sd128;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_x;
    logic [GAIN_W-1:0] gain_y;
    logic [GAIN_W-1:0] gain_z;
    logic [GAIN_W-1:0] divisor;
  } cfg_t;

  typedef struct packed {
    logic                    en;
    logic signed [OPA_W-1:0] a;
    logic signed [OPB_W-1:0] b;
  } mul_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PICK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_MUL_A,
    PH_MUL_B,
    PH_DIFF,
    PH_GAIN,
    PH_STORE
  } phase_t;

endpackage

// File: rtl/core/magnetorquer_axis_select.sv
// Top level of the magnetorquer axis select block.
//
//   channel  direction  handshake              payload
//   s_*      in         s_tvalid / s_tready    s_tdata: mag x,y,z, rate x,y,z
//   m_*      out        m_tvalid / m_tready    m_tdata: axis, power; m_tuser: updated
//   p*       in         psel, penable, pready  gain_x, gain_y, gain_z, divisor
//
// After the input transfer the sequencer runs five phases per axis (three of them
// products) and one pick state, then no division when no axis wins, else a
// saturation check and up to seven restoring steps, and then loads the output
// register. s_tready rises together with m_tvalid, so a new input transfer is
// taken only once the previous item is finished.
// A waiting result does not block the next input transfer; a finished item
// holds in its completion state only while the output register is still full.
// Reset is synchronous; it restores the register defaults and axis x, power 0.
module magnetorquer_axis_select (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // mag_x, mag_y, mag_z, rate_x, rate_y, rate_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // drive_axis[1:0], drive_power[9:2], zero fill
  output logic [0:0]  m_tuser,   // updated
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mts_pkg::*;

  cfg_t                    cfg;
  mul_req_t                mul_req;
  logic signed [PROD_W-1:0] prod;

  mts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mts_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  mts_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .mul_req  (mul_req),
    .prod     (prod)
  );

endmodule

// File: rtl/core/mts_regs.sv
// Configuration register file behind the APB-style port.
module mts_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mts_pkg::cfg_t      cfg
);
  import mts_pkg::*;

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];

  // Write a register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_x  <= RST_GAIN_X;
      cfg.gain_y  <= RST_GAIN_Y;
      cfg.gain_z  <= RST_GAIN_Z;
      cfg.divisor <= RST_DIVISOR;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_X:  cfg.gain_x  <= pwdata[GAIN_W-1:0];
        REG_GAIN_Y:  cfg.gain_y  <= pwdata[GAIN_W-1:0];
        REG_GAIN_Z:  cfg.gain_z  <= pwdata[GAIN_W-1:0];
        REG_DIVISOR: cfg.divisor <= pwdata[GAIN_W-1:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_GAIN_X:  prdata = 32'(cfg.gain_x);
      REG_GAIN_Y:  prdata = 32'(cfg.gain_y);
      REG_GAIN_Z:  prdata = 32'(cfg.gain_z);
      REG_DIVISOR: prdata = 32'(cfg.divisor);
    endcase
  end

endmodule

// File: rtl/core/mts_mul.sv
// Shared signed multiplier with registered product.
module mts_mul (
  input  logic                                  clk,
  input  mts_pkg::mul_req_t                     req,
  output logic signed [mts_pkg::PROD_W-1:0]     prod
);
  import mts_pkg::*;

  logic signed [OPA_W-1:0] a;
  logic signed [OPB_W-1:0] b;

  assign a = req.a;
  assign b = req.b;

  // Capture the product when the sequencer issues an operation
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= a * b;
    end
  end

endmodule

// File: rtl/core/mts_seq.sv
// Sequencer and datapath: cross terms, gain scaling, axis pick and division.
module mts_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  mts_pkg::cfg_t                       cfg,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [95:0]                         s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,
  output logic [0:0]                          m_tuser,
  output mts_pkg::mul_req_t                   mul_req,
  input  logic signed [mts_pkg::PROD_W-1:0]   prod
);
  import mts_pkg::*;

  state_t state, state_next;
  phase_t phase;
  logic [1:0] axis;

  logic signed [SAMPLE_W-1:0] mag [3];
  logic signed [SAMPLE_W-1:0] rate [3];

  logic signed [TERM_W-1:0] first;
  logic signed [OPA_W-1:0]  diff;
  logic [MAG_W-1:0]         score_mag [3];
  logic                     score_neg [3];

  logic              win_ok;
  logic [1:0]        win_axis;
  logic              win_neg;
  logic [MAG_W-1:0]  rem;
  logic [QUOT_W-1:0] quot;
  logic [2:0]        div_cnt;
  logic              sat;

  logic [1:0]        out_axis;
  logic signed [7:0] out_power;
  logic              out_updated;

  logic                       accept;
  logic                       out_free;
  logic signed [SAMPLE_W-1:0] op_m1, op_g1, op_m2, op_g2;
  logic [GAIN_W-1:0]          gain_sel;
  logic signed [TERM_W-1:0]   term;
  logic signed [MAG_W-1:0]    score;
  logic [MAG_W-1:0]           score_abs;
  logic                       w0, w1, w2;
  logic [MAG_W-1:0]           dshift;
  logic                       ge;
  logic signed [7:0]          power;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign m_tdata = {6'd0, out_power, out_axis};
  assign m_tuser = out_updated;

  // Pick the two cross-term operand pairs for the current axis
  always_comb begin
    unique case (axis)
      AXIS_Y: begin
        op_m1 = mag[2]; op_g1 = rate[0]; op_m2 = mag[0]; op_g2 = rate[2];
        gain_sel = cfg.gain_y;
      end
      AXIS_Z: begin
        op_m1 = mag[0]; op_g1 = rate[1]; op_m2 = mag[1]; op_g2 = rate[0];
        gain_sel = cfg.gain_z;
      end
      default: begin
        op_m1 = mag[1]; op_g1 = rate[2]; op_m2 = mag[2]; op_g2 = rate[1];
        gain_sel = cfg.gain_x;
      end
    endcase
  end

  // Drive the shared multiplier
  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = OPA_W'(op_m1);
    mul_req.b  = OPB_W'(op_g1);
    if (state == ST_MUL) begin
      unique case (phase)
        PH_MUL_A: begin
          mul_req.en = 1'b1;
        end
        PH_MUL_B: begin
          mul_req.en = 1'b1;
          mul_req.a  = OPA_W'(op_m2);
          mul_req.b  = OPB_W'(op_g2);
        end
        PH_GAIN: begin
          mul_req.en = 1'b1;
          mul_req.a  = diff;
          mul_req.b  = $signed({1'b0, gain_sel});
        end
        default: begin
          mul_req.en = 1'b0;
        end
      endcase
    end
  end

  // Score magnitude, strict winner and one division step
  assign term      = prod[TERM_W-1:0];
  assign score     = prod[MAG_W-1:0];
  assign score_abs = score[MAG_W-1] ? MAG_W'(-score) : MAG_W'(score);

  assign w0 = (score_mag[0] > score_mag[1]) && (score_mag[0] > score_mag[2]);
  assign w1 = (score_mag[1] > score_mag[0]) && (score_mag[1] > score_mag[2]);
  assign w2 = (score_mag[2] > score_mag[0]) && (score_mag[2] > score_mag[1]);

  assign dshift = MAG_W'(cfg.divisor) << div_cnt;
  assign ge     = (rem >= dshift);

  always_comb begin
    if (sat) begin
      power = win_neg ? POWER_MIN : POWER_MAX;
    end else if (win_neg) begin
      power = 8'sd0 - $signed({1'b0, quot});
    end else begin
      power = $signed({1'b0, quot});
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_MUL;
      ST_MUL:  if (phase == PH_STORE && axis == AXIS_Z) state_next = ST_PICK;
      ST_PICK: state_next = (w0 || w1 || w2) ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if ((div_cnt == 3'd7 && ge) || div_cnt == 3'd0) state_next = ST_DONE;
      end
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MUL_A;
      axis  <= AXIS_X;
    end else if (state == ST_MUL) begin
      unique case (phase)
        PH_MUL_A: phase <= PH_MUL_B;
        PH_MUL_B: phase <= PH_DIFF;
        PH_DIFF:  phase <= PH_GAIN;
        PH_GAIN:  phase <= PH_STORE;
        PH_STORE: begin
          phase <= PH_MUL_A;
          axis  <= (axis == AXIS_Z) ? AXIS_X : axis + 2'd1;
        end
        default: phase <= PH_MUL_A;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mag[0]  <= s_tdata[15:0];
          mag[1]  <= s_tdata[31:16];
          mag[2]  <= s_tdata[47:32];
          rate[0] <= s_tdata[63:48];
          rate[1] <= s_tdata[79:64];
          rate[2] <= s_tdata[95:80];
        end
      end
      ST_MUL: begin
        if (phase == PH_MUL_B) first <= term;
        if (phase == PH_DIFF)  diff  <= OPA_W'(first) - OPA_W'(term);
        if (phase == PH_STORE) begin
          score_mag[axis] <= score_abs;
          score_neg[axis] <= score[MAG_W-1];
        end
      end
      ST_PICK: begin
        // Start the division at the saturation check
        quot    <= '0;
        sat     <= 1'b0;
        div_cnt <= 3'd7;
        win_ok  <= w0 || w1 || w2;
        priority if (w0) begin
          win_axis <= AXIS_X; rem <= score_mag[0]; win_neg <= score_neg[0];
        end else if (w1) begin
          win_axis <= AXIS_Y; rem <= score_mag[1]; win_neg <= score_neg[1];
        end else begin
          win_axis <= AXIS_Z; rem <= score_mag[2]; win_neg <= score_neg[2];
        end
      end
      ST_DIV: begin
        if (div_cnt == 3'd7) begin
          sat <= ge;
        end else if (ge) begin
          rem  <= rem - dshift;
          quot <= quot | (QUOT_W'(1) << div_cnt);
        end
        div_cnt <= div_cnt - 3'd1;
      end
      default: begin
      end
    endcase
  end

  // Output register; it also holds the last driven axis and power
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      out_axis    <= AXIS_X;
      out_power   <= 8'sd0;
      out_updated <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid    <= 1'b1;
        out_updated <= win_ok;
        if (win_ok) begin
          out_axis  <= win_axis;
          out_power <= power;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken again while an item is in progress");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the completion state");

  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (axis == AXIS_X && phase == PH_MUL_A))
    else $error("sequencer counters not rewound at idle");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt != 3'd7)
      |-> rem < (MAG_W'(cfg.divisor) << (4'(div_cnt) + 4'd1)))
    else $error("remainder exceeds the division bound");

endmodule
